>>> design/gcd_fraction_reducer_unit_defines.svh
// Assertion macros used by the fraction reducer core.
`ifndef GCD_FRACTION_REDUCER_UNIT_DEFINES_SVH
`define GCD_FRACTION_REDUCER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante, on clk, outside reset.
`define GFR_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante, on clk, outside reset.
`define GFR_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/gfr_pkg.sv
// Shared types and constants of the fraction reducer.
package gfr_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int DATA_BITS      = 64;
	localparam int DIV_BITS       = 63;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] top_value;
		logic signed [DATA_BITS-1:0] bottom_value;
	} request_t;

	typedef struct packed {
		logic [DIV_BITS-1:0]         common_divisor;
		logic signed [DATA_BITS-1:0] reduced_top;
		logic signed [DATA_BITS-1:0] reduced_bottom;
		logic                        both_zero;
	} result_t;

	typedef struct packed {
		logic start;
		logic take;
	} core_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic both_zero;
		logic top_neg;
		logic bottom_neg;
	} core_status_t;

endpackage

>>> design/gfr_sub.sv
// Shared subtract and compare unit of the reducer datapath.
module gfr_sub #(
	parameter int WIDTH = gfr_pkg::VALUE_BITS_DEF
) (
	input  logic [WIDTH-1:0] x,
	input  logic [WIDTH-1:0] y,
	output logic [WIDTH-1:0] diff,
	output logic             ge
);

	logic [WIDTH:0] sum;

	// Add the complement: the carry out is set when x >= y
	assign sum  = {1'b0, x} + {1'b0, ~y} + {{WIDTH{1'b0}}, 1'b1};
	assign diff = sum[WIDTH-1:0];
	assign ge   = sum[WIDTH];

endmodule

>>> design/gfr_core.sv
// Sequencer and registers for binary GCD and two restoring divisions.
`include "gcd_fraction_reducer_unit_defines.svh"

module gfr_core #(
	parameter int MAG_BITS = gfr_pkg::VALUE_BITS_DEF - 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gfr_pkg::core_ctrl_t   ctrl,
	input  logic [MAG_BITS-1:0]   top_mag,
	input  logic [MAG_BITS-1:0]   bottom_mag,
	input  logic                  top_neg,
	input  logic                  bottom_neg,
	output gfr_pkg::core_status_t status,
	output logic [MAG_BITS-1:0]   divisor,
	output logic [MAG_BITS-1:0]   quot_top,
	output logic [MAG_BITS-1:0]   quot_bottom
);

	localparam int CNT_BITS = $clog2(MAG_BITS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_GCD   = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_DIV_T = 3'd3;
	localparam logic [2:0] ST_DIV_B = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]          state_q, state_d;
	logic [MAG_BITS-1:0] a_q, a_d;
	logic [MAG_BITS-1:0] b_q, b_d;
	logic [MAG_BITS-1:0] g_q, g_d;
	logic [MAG_BITS-1:0] r_q, r_d;
	logic [MAG_BITS-1:0] mt_q, mt_d;
	logic [MAG_BITS-1:0] mb_q, mb_d;
	logic [MAG_BITS-1:0] qt_q, qt_d;
	logic [MAG_BITS-1:0] qb_q, qb_d;
	logic [CNT_BITS-1:0] k_q, k_d;
	logic [CNT_BITS-1:0] cnt_q, cnt_d;
	logic                top_neg_q, top_neg_d;
	logic                bot_neg_q, bot_neg_d;
	logic                both_zero_q, both_zero_d;

	logic                div_phase;
	logic [MAG_BITS:0]   trial;
	logic [MAG_BITS:0]   sub_x;
	logic [MAG_BITS:0]   sub_y;
	logic [MAG_BITS:0]   sub_diff;
	logic                sub_ge;

	// Route operands of the shared subtractor by phase
	assign div_phase = (state_q == ST_DIV_T) || (state_q == ST_DIV_B);
	assign trial     = {r_q, a_q[MAG_BITS-1]};
	assign sub_x     = div_phase ? trial : {1'b0, a_q};
	assign sub_y     = div_phase ? {1'b0, g_q} : {1'b0, b_q};

	gfr_sub #(
		.WIDTH(MAG_BITS + 1)
	) u_sub (
		.x   (sub_x),
		.y   (sub_y),
		.diff(sub_diff),
		.ge  (sub_ge)
	);

	// Advance the sequencer one step
	always_comb begin
		logic [MAG_BITS-1:0] quo_next;
		quo_next    = {a_q[MAG_BITS-2:0], sub_ge};
		state_d     = state_q;
		a_d         = a_q;
		b_d         = b_q;
		g_d         = g_q;
		r_d         = r_q;
		mt_d        = mt_q;
		mb_d        = mb_q;
		qt_d        = qt_q;
		qb_d        = qb_q;
		k_d         = k_q;
		cnt_d       = cnt_q;
		top_neg_d   = top_neg_q;
		bot_neg_d   = bot_neg_q;
		both_zero_d = both_zero_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ctrl.start) begin
					a_d         = top_mag;
					b_d         = bottom_mag;
					mt_d        = top_mag;
					mb_d        = bottom_mag;
					k_d         = '0;
					top_neg_d   = top_neg;
					bot_neg_d   = bottom_neg;
					both_zero_d = (top_mag == '0) && (bottom_mag == '0);
					if ((top_mag == '0) && (bottom_mag == '0)) begin
						g_d     = '0;
						qt_d    = '0;
						qb_d    = '0;
						state_d = ST_DONE;
					end else begin
						state_d = ST_GCD;
					end
				end
			end
			ST_GCD: begin
				if ((a_q == '0) || (b_q == '0)) begin
					// One side is exhausted: the other holds the odd part
					g_d = a_q | b_q;
					if (k_q == '0) begin
						a_d     = mt_q;
						r_d     = '0;
						cnt_d   = CNT_BITS'(MAG_BITS);
						state_d = ST_DIV_T;
					end else begin
						state_d = ST_SHIFT;
					end
				end else if (!a_q[0] && !b_q[0]) begin
					a_d = a_q >> 1;
					b_d = b_q >> 1;
					k_d = k_q + CNT_BITS'(1);
				end else if (!a_q[0]) begin
					a_d = a_q >> 1;
				end else if (!b_q[0]) begin
					b_d = b_q >> 1;
				end else if (sub_ge) begin
					a_d = sub_diff[MAG_BITS-1:0];
				end else begin
					// Swap so the next step subtracts the smaller one
					a_d = b_q;
					b_d = a_q;
				end
			end
			ST_SHIFT: begin
				if (k_q == '0) begin
					a_d     = mt_q;
					r_d     = '0;
					cnt_d   = CNT_BITS'(MAG_BITS);
					state_d = ST_DIV_T;
				end else begin
					g_d = g_q << 1;
					k_d = k_q - CNT_BITS'(1);
				end
			end
			ST_DIV_T, ST_DIV_B: begin
				r_d   = sub_ge ? sub_diff[MAG_BITS-1:0] : trial[MAG_BITS-1:0];
				a_d   = quo_next;
				cnt_d = cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					if (state_q == ST_DIV_T) begin
						qt_d    = quo_next;
						a_d     = mb_q;
						r_d     = '0;
						cnt_d   = CNT_BITS'(MAG_BITS);
						state_d = ST_DIV_B;
					end else begin
						qb_d    = quo_next;
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (ctrl.take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the datapath registers
	always_ff @(posedge clk) begin
		a_q         <= a_d;
		b_q         <= b_d;
		g_q         <= g_d;
		r_q         <= r_d;
		mt_q        <= mt_d;
		mb_q        <= mb_d;
		qt_q        <= qt_d;
		qb_q        <= qb_d;
		k_q         <= k_d;
		cnt_q       <= cnt_d;
		top_neg_q   <= top_neg_d;
		bot_neg_q   <= bot_neg_d;
		both_zero_q <= both_zero_d;
	end

	assign status.busy       = (state_q != ST_IDLE);
	assign status.done       = (state_q == ST_DONE);
	assign status.both_zero  = both_zero_q;
	assign status.top_neg    = top_neg_q;
	assign status.bottom_neg = bot_neg_q;
	assign divisor           = g_q;
	assign quot_top          = qt_q;
	assign quot_bottom       = qb_q;

	`GFR_CHECK(a_rem_below_div, div_phase, r_q < g_q, "remainder reached the divisor")
	`GFR_CHECK(a_div_nonzero, div_phase, g_q != '0, "division by a zero divisor")
	`GFR_CHECK(a_gcd_live, state_q == ST_GCD, (a_q != '0) || (b_q != '0), "gcd operands lost")
	`GFR_CHECK_NEXT(a_take_idle, status.done && ctrl.take, state_q == ST_IDLE, "no idle after take")

endmodule

>>> design/gcd_fraction_reducer_unit.sv
// Top level of the fraction reducer: operand conditioning, core and output register.
//
//   channel  | direction | handshake                      | payload
//   request  | in        | request_valid / request_stall  | gfr_pkg::request_t
//   result   | out       | result_valid / result_stall    | gfr_pkg::result_t
//
// One request runs the binary GCD loop (data dependent), then re-shifts the common factors of
// two into the divisor, then the two exact divisions of the magnitudes by it; the GCD
// subtractions and the divisions all run on the single shared subtractor. Two zero operands
// skip the loop and the divisions: the sequencer goes straight from acceptance to its done
// state, and the next request can be accepted once that result is taken.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// request_stall is high from acceptance until the result moves into the output register,
// which happens while a previous result still waits only once that one is taken.
module gcd_fraction_reducer_unit #(
	parameter int VALUE_BITS = gfr_pkg::VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              request_valid,
	output logic              request_stall,
	input  gfr_pkg::request_t request,
	output logic              result_valid,
	input  logic              result_stall,
	output gfr_pkg::result_t  result
);

	localparam int MAG_BITS = VALUE_BITS - 1;

	gfr_pkg::core_ctrl_t   ctrl;
	gfr_pkg::core_status_t status;
	logic [MAG_BITS-1:0]   top_mag;
	logic [MAG_BITS-1:0]   bottom_mag;
	logic [MAG_BITS-1:0]   divisor;
	logic [MAG_BITS-1:0]   quot_top;
	logic [MAG_BITS-1:0]   quot_bottom;
	logic [gfr_pkg::DIV_BITS-1:0]  div_ext;
	logic [gfr_pkg::DATA_BITS-1:0] top_ext;
	logic [gfr_pkg::DATA_BITS-1:0] bot_ext;
	logic                  take;
	logic                  result_valid_q;
	gfr_pkg::result_t      result_q;

	// Magnitude of a sign-extended operand, most negative value saturated
	function automatic logic [MAG_BITS-1:0] magnitude_of(input logic [VALUE_BITS-1:0] raw);
		logic [VALUE_BITS-1:0] neg_raw;
		neg_raw = ~raw + VALUE_BITS'(1);
		if (raw == {1'b1, {MAG_BITS{1'b0}}}) begin
			return {MAG_BITS{1'b1}};
		end else if (raw[MAG_BITS]) begin
			return neg_raw[MAG_BITS-1:0];
		end else begin
			return raw[MAG_BITS-1:0];
		end
	endfunction

	// Condition operands from the low field bits
	assign top_mag    = magnitude_of(request.top_value[VALUE_BITS-1:0]);
	assign bottom_mag = magnitude_of(request.bottom_value[VALUE_BITS-1:0]);

	// Accept a request only while the core is idle
	assign request_stall = status.busy;
	assign ctrl.start    = request_valid && !status.busy;
	assign take          = status.done && (!result_valid_q || !result_stall);
	assign ctrl.take     = take;

	gfr_core #(
		.MAG_BITS(MAG_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.top_mag    (top_mag),
		.bottom_mag (bottom_mag),
		.top_neg    (request.top_value[VALUE_BITS-1]),
		.bottom_neg (request.bottom_value[VALUE_BITS-1]),
		.status     (status),
		.divisor    (divisor),
		.quot_top   (quot_top),
		.quot_bottom(quot_bottom)
	);

	// Widen core results to the field widths
	always_comb begin
		div_ext = '0;
		top_ext = '0;
		bot_ext = '0;
		div_ext[MAG_BITS-1:0] = divisor;
		top_ext[MAG_BITS-1:0] = quot_top;
		bot_ext[MAG_BITS-1:0] = quot_bottom;
	end

	// Hold the result valid until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Load the result payload, restoring the operand signs
	always_ff @(posedge clk) begin
		if (take) begin
			result_q.common_divisor <= div_ext;
			result_q.reduced_top    <= status.top_neg ? ('0 - top_ext) : top_ext;
			result_q.reduced_bottom <= status.bottom_neg ? ('0 - bot_ext) : bot_ext;
			result_q.both_zero      <= status.both_zero;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
